[rtl/htcis_pkg.sv]
package htcis_pkg;

  // Default sizing of the selection range and of the tick counters.
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int TICK_BITS_DEF   = 16;

  // Fixed field widths.
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int INDEX_W     = 9;
  localparam int ELAPSED_W   = 16;
  localparam int THRESH_W    = 16;
  localparam int COUNT_W     = 9;
  localparam int SOURCE_W    = 2;
  localparam int JUMP_W      = 8;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT = 2'd2;

  // Register values after reset.
  localparam logic [THRESH_W-1:0]   THRESHOLD_RST = 16'd500;
  localparam logic [CFG_DATA_W-1:0] COOLDOWN_RST  = 16'd1000;

  typedef enum logic [1:0] {
    KIND_BEGIN,
    KIND_END,
    KIND_TICK,
    KIND_NOP
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_NEXT,
    ACT_PREV,
    ACT_JUMP
  } action_t;

  typedef struct packed {
    kind_t               kind;
    action_t             action;
    logic [SOURCE_W-1:0] source;
    logic [JUMP_W-1:0]   jump_index;
    logic                hibernating;
  } item_t;

  typedef struct packed {
    logic signed [INDEX_W-1:0] current_index;
    logic                      load_request;
    action_t                   held_action;
    logic [ELAPSED_W-1:0]      hold_elapsed;
    logic                      in_cooldown;
  } result_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

endpackage

[rtl/htcis_core.sv]
module htcis_core #(
  parameter int MAX_ENTRIES = htcis_pkg::MAX_ENTRIES_DEF,
  parameter int TICK_BITS   = htcis_pkg::TICK_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  htcis_pkg::cfg_write_t  cfg,
  input  logic                   step,
  input  htcis_pkg::item_t       item,
  output htcis_pkg::result_t     result
);
  import htcis_pkg::*;

  // Largest entry count the 9-bit register can express, capped by the parameter.
  localparam int CAP    = (MAX_ENTRIES < 511) ? MAX_ENTRIES : 511;
  localparam int CNT_EW = $clog2(CAP + 1);
  localparam int SEL_W  = $clog2(CAP) + 1;
  localparam int XW     = (SEL_W + 1 > 10) ? SEL_W + 1 : 10;
  localparam int OW     = (SEL_W > INDEX_W) ? SEL_W : INDEX_W;
  // Tick counters never need to exceed the 16-bit configured values.
  localparam int CNT_W  = (TICK_BITS < THRESH_W) ? TICK_BITS : THRESH_W;
  localparam logic [THRESH_W-1:0] CNT_MAX16 = THRESH_W'((64'd1 << CNT_W) - 64'd1);

  // Configuration registers.
  logic [THRESH_W-1:0]   threshold;
  logic [CFG_DATA_W-1:0] cooldown_cfg;
  logic [CNT_EW-1:0]     entry_count;

  // Navigation state.
  logic signed [SEL_W-1:0] selected, selected_next;
  action_t                 hold_kind, hold_kind_next;
  logic [SOURCE_W-1:0]     hold_origin, hold_origin_next;
  logic [JUMP_W-1:0]       jump_target, jump_target_next;
  logic [CNT_W-1:0]        hold_ticks, hold_ticks_next;
  logic [CNT_W-1:0]        cooldown_left, cooldown_left_next;
  logic                    load_next;

  logic signed [XW-1:0] sel_x, cnt_x, jidx_x, jt_x;
  logic [CNT_W-1:0]     hold_limit, cooldown_load, ticks_bumped;
  logic                 next_blocked, prev_blocked, jump_blocked, jt_blocked;
  logic                 same_hold, begin_refused;
  logic [COUNT_W-1:0]   count_sat;
  logic signed [OW-1:0] sel_out;

  // Signed views for the range checks.
  assign sel_x  = XW'(selected);
  assign cnt_x  = $signed({{(XW-CNT_EW){1'b0}}, entry_count});
  assign jidx_x = $signed({{(XW-JUMP_W){1'b0}}, item.jump_index});
  assign jt_x   = $signed({{(XW-JUMP_W){1'b0}}, jump_target});

  // Moves that would do nothing against the present selection and count.
  assign next_blocked = (sel_x + XW'(1)) >= cnt_x;
  assign prev_blocked = (sel_x <= XW'(0));
  assign jump_blocked = (jidx_x >= cnt_x) || (jidx_x == sel_x);
  assign jt_blocked   = (jt_x >= cnt_x) || (jt_x == sel_x);

  assign same_hold = (hold_kind == item.action) && (hold_origin == item.source) &&
                     ((item.action != ACT_JUMP) || (jump_target == item.jump_index));

  assign begin_refused = (item.action == ACT_NONE) || (cooldown_left != '0) ||
                         item.hibernating || same_hold ||
                         ((item.action == ACT_NEXT) && next_blocked) ||
                         ((item.action == ACT_PREV) && prev_blocked) ||
                         ((item.action == ACT_JUMP) && jump_blocked);

  // Counter limits saturated to the counter width.
  assign hold_limit    = (threshold > CNT_MAX16) ? CNT_W'(CNT_MAX16) : CNT_W'(threshold);
  assign cooldown_load = (cooldown_cfg > CNT_MAX16) ? CNT_W'(CNT_MAX16)
                                                    : CNT_W'(cooldown_cfg);
  assign ticks_bumped  = (hold_ticks < hold_limit) ? hold_ticks + 1'b1 : hold_ticks;

  // An entry count whose low 9 bits exceed the capacity is clamped to it.
  assign count_sat = (cfg.data[COUNT_W-1:0] > COUNT_W'(CAP)) ? COUNT_W'(CAP)
                                                             : cfg.data[COUNT_W-1:0];

  // Next state for one word.
  always_comb begin
    selected_next      = selected;
    hold_kind_next     = hold_kind;
    hold_origin_next   = hold_origin;
    jump_target_next   = jump_target;
    hold_ticks_next    = hold_ticks;
    cooldown_left_next = cooldown_left;
    load_next          = 1'b0;
    case (item.kind)
      KIND_BEGIN: begin
        if (!begin_refused) begin
          hold_kind_next   = item.action;
          hold_origin_next = item.source;
          jump_target_next = item.jump_index;
          hold_ticks_next  = '0;
        end
      end
      KIND_END: begin
        if (hold_origin == item.source) begin
          hold_kind_next   = ACT_NONE;
          hold_origin_next = '0;
          hold_ticks_next  = '0;
        end
      end
      KIND_TICK: begin
        if (cooldown_left != '0) begin
          cooldown_left_next = cooldown_left - 1'b1;
        end
        if (hold_kind != ACT_NONE) begin
          hold_ticks_next = ticks_bumped;
          if (THRESH_W'(ticks_bumped) >= threshold) begin
            // The hold fires: clear it, start the cooldown, retry the move.
            hold_kind_next     = ACT_NONE;
            hold_origin_next   = '0;
            hold_ticks_next    = '0;
            cooldown_left_next = cooldown_load;
            case (hold_kind)
              ACT_NEXT: begin
                if (!next_blocked) begin
                  selected_next = SEL_W'(sel_x + XW'(1));
                  load_next     = 1'b1;
                end
              end
              ACT_PREV: begin
                if (!prev_blocked) begin
                  selected_next = SEL_W'(sel_x - XW'(1));
                  load_next     = 1'b1;
                end
              end
              ACT_JUMP: begin
                if (!jt_blocked) begin
                  selected_next = SEL_W'(jt_x);
                  load_next     = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // State and configuration registers; a count write resets the selection.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RST;
      cooldown_cfg  <= COOLDOWN_RST;
      entry_count   <= '0;
      selected      <= '1;
      hold_kind     <= ACT_NONE;
      hold_origin   <= '0;
      hold_ticks    <= '0;
      cooldown_left <= '0;
    end else begin
      if (step) begin
        selected      <= selected_next;
        hold_kind     <= hold_kind_next;
        hold_origin   <= hold_origin_next;
        hold_ticks    <= hold_ticks_next;
        cooldown_left <= cooldown_left_next;
      end
      if (cfg.we) begin
        case (cfg.index)
          CFG_THRESHOLD: threshold <= cfg.data[THRESH_W-1:0];
          CFG_COOLDOWN: cooldown_cfg <= cfg.data;
          CFG_ENTRY_COUNT: begin
            entry_count <= CNT_EW'(count_sat);
            selected    <= (count_sat == '0) ? '1 : '0;
          end
          default: ;
        endcase
      end
    end
  end

  // The jump target is only read while a jump is held.
  always_ff @(posedge clk) begin
    if (step) begin
      jump_target <= jump_target_next;
    end
  end

  // Status after this word.
  assign sel_out              = OW'(selected_next);
  assign result.current_index = sel_out[INDEX_W-1:0];
  assign result.load_request  = load_next;
  assign result.held_action   = hold_kind_next;
  assign result.hold_elapsed  = ELAPSED_W'(hold_ticks_next);
  assign result.in_cooldown   = (cooldown_left_next != '0);

endmodule

[rtl/hold_to_confirm_index_stepper.sv]
// A word is captured in the input register and offered from the result register after the state update.
// Throughput: one word per cycle unless the result stalls; the input register and the result register
// are separated by a single pass of the state update logic in htcis_core.
// A stalled result holds in the output register while one more word waits.
// Reset (synchronous, active high) restores the register defaults, clears the
// hold and cooldown, sets the selection to -1 and empties both registers.
module hold_to_confirm_index_stepper #(
  parameter int MAX_ENTRIES = htcis_pkg::MAX_ENTRIES_DEF,
  parameter int TICK_BITS   = htcis_pkg::TICK_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [htcis_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [htcis_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   item_valid,
  output logic                                   item_stall,
  input  logic [1:0]                             kind,
  input  logic [1:0]                             requested_action,
  input  logic [htcis_pkg::SOURCE_W-1:0]         source,
  input  logic [htcis_pkg::JUMP_W-1:0]           jump_index,
  input  logic                                   hibernating,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [htcis_pkg::INDEX_W-1:0]   current_index,
  output logic                                   load_request,
  output logic [1:0]                             held_action,
  output logic [htcis_pkg::ELAPSED_W-1:0]        hold_elapsed,
  output logic                                   in_cooldown
);
  import htcis_pkg::*;

  item_t      item_reg;
  logic       item_reg_valid;
  result_t    result_reg;
  result_t    core_result;
  cfg_write_t cfg;
  logic       advance, item_take, step;

  // Handshake: the held word moves on whenever the result register is free.
  assign advance    = !result_valid || !result_stall;
  assign item_stall = item_reg_valid && !advance;
  assign item_take  = item_valid && !item_stall;
  assign step       = item_reg_valid && advance;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Valid flags of the input and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      item_reg_valid <= item_take || (item_reg_valid && !advance);
      if (advance) begin
        result_valid <= item_reg_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_take) begin
      item_reg.kind        <= kind_t'(kind);
      item_reg.action      <= action_t'(requested_action);
      item_reg.source      <= source;
      item_reg.jump_index  <= jump_index;
      item_reg.hibernating <= hibernating;
    end
    if (step) begin
      result_reg <= core_result;
    end
  end

  htcis_core #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TICK_BITS   (TICK_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .item   (item_reg),
    .result (core_result)
  );

  assign current_index = result_reg.current_index;
  assign load_request  = result_reg.load_request;
  assign held_action   = result_reg.held_action;
  assign hold_elapsed  = result_reg.hold_elapsed;
  assign in_cooldown   = result_reg.in_cooldown;

endmodule

[rtl/htcis_checker.sv]
module htcis_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 result_valid,
  input logic                                 result_stall,
  input logic signed [htcis_pkg::INDEX_W-1:0] current_index,
  input logic                                 load_request,
  input logic [1:0]                           held_action,
  input logic [htcis_pkg::ELAPSED_W-1:0]      hold_elapsed,
  input logic                                 in_cooldown
);
  import htcis_pkg::*;

  // A stalled result word stays put.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(current_index) &&
      $stable(load_request) && $stable(held_action) && $stable(hold_elapsed) &&
      $stable(in_cooldown))
    else $error("result word changed while stalled");

  // A fired hold always leaves no hold pending.
  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    result_valid && load_request |-> held_action == ACT_NONE && hold_elapsed == '0)
    else $error("hold still pending after a load request");

  // Elapsed time is only counted for a pending hold.
  a_idle_elapsed: assert property (@(posedge clk) disable iff (rst)
    result_valid && held_action == ACT_NONE |-> hold_elapsed == '0)
    else $error("elapsed ticks without a hold");

  // Cooldown starts only when a hold fires and refuses new holds until it ends.
  a_cooldown_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid && in_cooldown |-> held_action == ACT_NONE)
    else $error("hold pending during cooldown");

endmodule

bind hold_to_confirm_index_stepper htcis_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .current_index (current_index),
  .load_request  (load_request),
  .held_action   (held_action),
  .hold_elapsed  (hold_elapsed),
  .in_cooldown   (in_cooldown)
);
